// ===== design/tklb_pkg.sv =====
// Shared types and constants for the top-k score leaderboard.
// Holds field widths, the controller state type and the command/status structs.
// No dependencies.
package tklb_pkg;

	localparam int DEF_CAPACITY = 100;
	localparam int KEY_W        = 64;
	localparam int SCORE_W      = 64;
	localparam int RANK_W       = 7;
	localparam int ENTRY_W      = KEY_W + SCORE_W;
	localparam int IN_TDATA_W   = 128;
	localparam int OUT_TDATA_W  = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_SHIFT,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_en;
		logic resolve;
		logic shift_en;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic out_free;
	} status_t;

endpackage

// ===== design/tklb_ctrl.sv =====
// Controller state machine for the leaderboard: sequences scan, resolve,
// shift and commit phases. Depends on tklb_pkg.
module tklb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tklb_pkg::status_t sts,
	output tklb_pkg::cmd_t    cmd
);
	import tklb_pkg::*;

	state_t state_q, state_d;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (sts.shift_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan_en  = (state_q == ST_SCAN);
		cmd.resolve  = (state_q == ST_RESOLVE);
		cmd.shift_en = (state_q == ST_SHIFT);
		cmd.commit   = (state_q == ST_COMMIT) && sts.out_free;
	end

endmodule

// ===== design/tklb_datapath.sv =====
// Datapath for the leaderboard: entry memory, key search with rank count,
// entry shifter and result register. Depends on tklb_pkg.
module tklb_datapath #(
	parameter int CAPACITY = tklb_pkg::DEF_CAPACITY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tklb_pkg::cmd_t                  cmd,
	output tklb_pkg::status_t               sts,
	input  logic [tklb_pkg::KEY_W-1:0]      in_key,
	input  logic signed [tklb_pkg::SCORE_W-1:0] in_score,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tklb_pkg::RANK_W-1:0]     out_rank,
	output logic [tklb_pkg::RANK_W-1:0]     out_count,
	output logic                            out_present
);
	import tklb_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
	localparam logic [CW-1:0] CAPM1_C = CW'(CAPACITY - 1);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// entry memory: score in the upper half, key in the lower half
	logic [ENTRY_W-1:0] mem [CAPACITY];
	logic [ENTRY_W-1:0] rd_data_q;

	logic [KEY_W-1:0]          key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             ptr_q;
	logic [CW-1:0]             rem_q;
	logic                      up_q;
	logic                      found_q;
	logic [CW-1:0]             fidx_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             tgt_q;
	logic                      drop_q;
	logic                      scan_vld_s1;
	logic                      shift_vld_s1;
	logic [CW-1:0]             addr_s1;
	logic                      out_valid_q;
	logic [RANK_W-1:0]         out_rank_q;
	logic [RANK_W-1:0]         out_count_q;
	logic                      out_present_q;

	logic                      scan_issue;
	logic                      shift_issue;
	logic                      rd_en;
	logic [KEY_W-1:0]          rd_key;
	logic signed [SCORE_W-1:0] rd_score;
	logic [CW-1:0]             src;
	logic [CW-1:0]             shift_waddr;
	logic [CW-1:0]             new_count;
	logic [CW:0]               rank_full;

	assign scan_issue  = cmd.scan_en && (ptr_q < count_q);
	assign shift_issue = cmd.shift_en && (rem_q != '0);
	assign rd_en       = scan_issue || shift_issue;
	assign rd_key      = rd_data_q[KEY_W-1:0];
	assign rd_score    = rd_data_q[ENTRY_W-1:KEY_W];
	assign shift_waddr = up_q ? (addr_s1 - ONE_C) : (addr_s1 + ONE_C);
	assign src         = found_q ? fidx_q : ((count_q < CAP_C) ? count_q : CAPM1_C);
	assign new_count   = (!found_q && (count_q < CAP_C)) ? (count_q + ONE_C) : count_q;
	assign rank_full   = drop_q ? '0 : ({1'b0, tgt_q} + {{CW{1'b0}}, 1'b1});

	// memory read and write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[ptr_q[IW-1:0]];
		end
		if (shift_vld_s1) begin
			mem[shift_waddr[IW-1:0]] <= rd_data_q;
		end else if (cmd.commit && !drop_q) begin
			mem[tgt_q[IW-1:0]] <= {score_q, key_q};
		end
	end

	// capture the incoming beat and the address of each memory read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= in_key;
			score_q <= in_score;
		end
		if (rd_en) begin
			addr_s1 <= ptr_q;
		end
	end

	// search, resolve, shift and entry count control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ptr_q        <= '0;
			rem_q        <= '0;
			up_q         <= 1'b0;
			found_q      <= 1'b0;
			fidx_q       <= '0;
			cnt_q        <= '0;
			tgt_q        <= '0;
			drop_q       <= 1'b0;
			scan_vld_s1  <= 1'b0;
			shift_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1  <= scan_issue;
			shift_vld_s1 <= shift_issue;
			if (cmd.load) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end
			if (scan_issue) begin
				ptr_q <= ptr_q + ONE_C;
			end
			// first key match marks the source slot; other entries count
			// toward the new place: ties ahead of the old slot stay ahead
			if (scan_vld_s1) begin
				if (!found_q && (rd_key == key_q)) begin
					found_q <= 1'b1;
					fidx_q  <= addr_s1;
				end else if (!found_q) begin
					if (rd_score >= score_q) cnt_q <= cnt_q + ONE_C;
				end else begin
					if (rd_score > score_q) cnt_q <= cnt_q + ONE_C;
				end
			end
			if (cmd.resolve) begin
				tgt_q  <= cnt_q;
				drop_q <= !found_q && (count_q == CAP_C) && (cnt_q == CAP_C);
				up_q   <= cnt_q > src;
				if (!found_q && (count_q == CAP_C) && (cnt_q == CAP_C)) begin
					rem_q <= '0;
				end else if (cnt_q > src) begin
					rem_q <= cnt_q - src;
					ptr_q <= src + ONE_C;
				end else begin
					rem_q <= src - cnt_q;
					ptr_q <= src - ONE_C;
				end
			end
			if (shift_issue) begin
				rem_q <= rem_q - ONE_C;
				ptr_q <= up_q ? (ptr_q + ONE_C) : (ptr_q - ONE_C);
			end
			if (cmd.commit) begin
				count_q <= new_count;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_rank_q    <= RANK_W'(rank_full);
			out_count_q   <= RANK_W'(new_count);
			out_present_q <= found_q;
		end
	end

	assign sts.scan_done  = (ptr_q == count_q) && !scan_vld_s1;
	assign sts.shift_done = (rem_q == '0) && !shift_vld_s1;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_rank    = out_rank_q;
	assign out_count   = out_count_q;
	assign out_present = out_present_q;

endmodule

// ===== design/top_k_score_leaderboard_top.sv =====
// Top level of the top-k score leaderboard.
// Instantiates tklb_ctrl and tklb_datapath; depends on tklb_pkg.
//
// Usage:
//   The slave channel takes one update per beat: a 64-bit key and a signed
//   64-bit score. The master channel returns one result beat per update:
//   the key's 1-based rank after the update (0 if it fell off the end of a
//   full board), the number of entries held and, in tuser, whether the key
//   was already on the board.
//   Entries sit in a single-port-read memory of CAPACITY rows kept in
//   descending score order; equal scores keep their earlier order.
//   An update runs as a key search that reads the n rows held before the
//   update, a resolve step, a shift that reads the d rows the entry moves
//   across, and a commit; one memory read is made per cycle. One update at
//   a time; the next is taken only once the current one has committed.
//   A finished result waits in the output register while the next update
//   is accepted; if the receiver stalls, the following update holds in its
//   commit step until the output register frees.
//   Reset empties the board at once (entry count zero); no clearing pass.
module top_k_score_leaderboard_top #(
	parameter int CAPACITY = tklb_pkg::DEF_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [63:0] entry_key, [127:64] entry_score
	input  logic [tklb_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [6:0] assigned_rank, [13:7] entry_count, [15:14] zero
	output logic [tklb_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] was_present
	output logic                               m_tuser
);
	import tklb_pkg::*;

	cmd_t              cmd;
	status_t           sts;
	logic [RANK_W-1:0] rank;
	logic [RANK_W-1:0] count;

	tklb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tklb_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_key      (s_tdata[KEY_W-1:0]),
		.in_score    (s_tdata[KEY_W+SCORE_W-1:KEY_W]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_rank    (rank),
		.out_count   (count),
		.out_present (m_tuser)
	);

	// pack the result beat
	assign m_tdata = {2'b00, count, rank};

endmodule

// ===== design/tklb_checker.sv =====
// Port-level checks for the top-k score leaderboard, bound to the top level.
// Depends on tklb_pkg and top_k_score_leaderboard_top.
module tklb_checker #(
	parameter int CAPACITY = tklb_pkg::DEF_CAPACITY
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [tklb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tklb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser
);
	import tklb_pkg::*;

	localparam bit FITS = (CAPACITY < 128);

	logic [RANK_W-1:0] rank;
	logic [RANK_W-1:0] count;
	logic              in_beat;

	assign rank    = m_tdata[RANK_W-1:0];
	assign count   = m_tdata[2*RANK_W-1:RANK_W];
	assign in_beat = s_tvalid && s_tready && (s_tdata != '1 || s_tdata == '1);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// count never exceeds the board size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && FITS |-> count <= RANK_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// a rank lies within the board
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && FITS |-> rank <= count)
		else $error("rank beyond entry count");

	// a replaced key always keeps a place
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && FITS |-> rank != '0 && count != '0)
		else $error("present key reported as dropped");

	// no update is taken in the cycle after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("update accepted while one is in progress");

endmodule

bind top_k_score_leaderboard_top tklb_checker #(
	.CAPACITY (CAPACITY)
) u_tklb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
